// ----- rtl/pfb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

   localparam int FRAME_BYTES   = 18;
   localparam int CRC_BYTES     = 16;
   localparam int BYTE_IDX_W    = $clog2(FRAME_BYTES);
   localparam int JOB_IDX_W     = $clog2(CRC_BYTES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNCTION_CODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_POLYNOMIAL = 2'd2;

   localparam logic [15:0] POLL_INTERVAL_RESET = 16'd20;
   localparam logic [7:0]  FUNCTION_CODE_RESET = 8'h00;
   localparam logic [15:0] CRC_POLY_RESET      = 16'hA001;
   localparam logic [15:0] CRC_INIT            = 16'hFFFF;
   localparam logic [31:0] ELAPSED_MAX         = 32'hFFFF_FFFF;

   localparam logic [BYTE_IDX_W-1:0] CRC_HIGH_IDX = BYTE_IDX_W'(CRC_BYTES);
   localparam logic [BYTE_IDX_W-1:0] LAST_IDX     = BYTE_IDX_W'(FRAME_BYTES - 1);

   localparam logic ACTION_TICK   = 1'b0;
   localparam logic ACTION_UPDATE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] input_state;
      logic [15:0] effect_state;
      logic [11:0] servo_one;
      logic [11:0] servo_two;
      logic [11:0] servo_three;
      logic [11:0] servo_four;
      logic [11:0] servo_five;
      logic [11:0] servo_six;
   } req_word_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] poll_interval_ms;
      logic [7:0]  function_code;
      logic [15:0] crc_polynomial;
   } cfg_type;

   // first sixteen frame bytes, byte 0 in the low bits
   typedef logic [CRC_BYTES*8-1:0] frame_type;

   typedef struct packed {
      logic      push;
      frame_type frame;
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/pfb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfb_queue
   import pfb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire job_type   job,
   input  wire logic      pop,
   output      logic      full,
   output      logic      empty,
   output      frame_type head
);

   frame_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = job.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= job.frame;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pfb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfb_front
   import pfb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_word_type req_word,
   input  wire logic         queue_full,
   output      job_type      job
);

   logic        waiting_ff, waiting_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      waiting_in = waiting_ff;
      elapsed_in = elapsed_ff;
      job.push   = 1'b0;
      job.frame  = {req_word.servo_six[7:0],
                    req_word.servo_five[3:0], req_word.servo_six[11:8],
                    req_word.servo_five[11:4],
                    req_word.servo_four[7:0],
                    req_word.servo_three[3:0], req_word.servo_four[11:8],
                    req_word.servo_three[11:4],
                    req_word.servo_two[7:0],
                    req_word.servo_one[3:0], req_word.servo_two[11:8],
                    req_word.servo_one[11:4],
                    req_word.effect_state,
                    req_word.input_state,
                    cfg.function_code};
      if (accept) begin
         if (req_word.action == ACTION_TICK) begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 32'd1;
            end
         end else if (waiting_ff) begin
            if (elapsed_ff > {16'h0000, cfg.poll_interval_ms}) begin
               waiting_in = 1'b0;
            end
         end else begin
            job.push   = 1'b1;
            waiting_in = 1'b1;
            elapsed_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b1;
         elapsed_ff <= '0;
      end else begin
         waiting_ff <= waiting_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pfb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfb_back
   import pfb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         queue_empty,
   input  wire frame_type    queue_head,
   output      logic         queue_pop,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_word_type rsp_word
);

   function automatic logic [15:0] crc_update(input logic [15:0] crc_prev,
                                              input logic [7:0]  data,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc_prev ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   frame_type              job_ff, job_in;
   logic                   busy_ff, busy_in;
   logic [BYTE_IDX_W-1:0]  idx_ff, idx_in;
   logic [15:0]            crc_ff, crc_in;
   logic                   valid_ff, valid_in;
   rsp_word_type           word_ff, word_in;
   logic                   out_free, advance, last;
   logic [7:0]             data_byte;

   assign out_free  = !valid_ff || !rsp_stall;
   assign advance   = busy_ff && out_free;
   assign last      = (idx_ff == LAST_IDX);
   assign queue_pop = (!busy_ff || (advance && last)) && !queue_empty;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_comb begin
      if (idx_ff == CRC_HIGH_IDX) begin
         data_byte = crc_ff[15:8];
      end else if (last) begin
         data_byte = crc_ff[7:0];
      end else begin
         data_byte = job_ff[{idx_ff[JOB_IDX_W-1:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      job_in   = job_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff && rsp_stall;
      word_in  = word_ff;
      if (advance) begin
         valid_in           = 1'b1;
         word_in.frame_byte = data_byte;
         word_in.last_byte  = last;
         idx_in             = idx_ff + 1'b1;
         if (idx_ff < CRC_HIGH_IDX) begin
            crc_in = crc_update(crc_ff, data_byte, cfg.crc_polynomial);
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (queue_pop) begin
         job_in  = queue_head;
         busy_in = 1'b1;
         idx_in  = '0;
         crc_in  = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      crc_ff  <= crc_in;
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// ----- rtl/polled_frame_builder_crc16_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Polled frame builder with reflected CRC-16. Ticks (action 0) advance a
// saturating millisecond count; updates (action 1) either move the block from
// waiting to idle once the count exceeds poll_interval_ms, or, when idle, queue
// an 18-byte frame and restart the count. The front takes each request word
// as it is accepted; a frame then leaves the result channel as 18 words, one
// byte per cycle while rsp_stall is low, with last_byte set on the CRC low
// byte. The byte-wide CRC unit in the back end sets the output rate; a
// two-entry frame queue lets requests keep flowing while a frame is out, and
// req_stall rises only when that queue is full. The user must write registers
// through the csr port only while the block is idle; it is not enforced.

module polled_frame_builder_crc16_core
   import pfb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_word_type           req_word,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_word_type           rsp_word
);

   cfg_type   cfg_ff, cfg_in;
   job_type   job;
   logic      queue_full, queue_empty, queue_pop;
   frame_type queue_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_POLL_INTERVAL:  cfg_in.poll_interval_ms = csr_wdata;
            CSR_FUNCTION_CODE:  cfg_in.function_code    = csr_wdata[7:0];
            CSR_CRC_POLYNOMIAL: cfg_in.crc_polynomial   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval_ms <= POLL_INTERVAL_RESET;
         cfg_ff.function_code    <= FUNCTION_CODE_RESET;
         cfg_ff.crc_polynomial   <= CRC_POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (queue_full),
      .job        (job)
   );

   pfb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .job   (job),
      .pop   (queue_pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (queue_head)
   );

   pfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

// ----- rtl/pfb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfb_checker
   import pfb_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // frame queue is empty after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   // a frame leaves without gaps until its last byte
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_word.last_byte |=> rsp_valid)
      else $error("gap inside a frame");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

endmodule

bind polled_frame_builder_crc16_core pfb_checker u_pfb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire
